// File: sv/spr_pkg.sv
`default_nettype none
package spr_pkg;

  localparam int NUM_CHANNELS = 7;
  localparam int POS_BITS     = 16;
  localparam int CH_BITS      = 3;
  localparam int CFG_BITS     = 16;
  localparam int TOP_BITS     = 16;
  localparam int TPS_BITS     = 8;
  localparam int CNT_BITS     = $clog2(POS_BITS);

  // register reset values
  localparam logic [TOP_BITS-1:0] PWM_TOP_RESET = TOP_BITS'(40000);
  localparam logic [POS_BITS-1:0] REST_RESET    = POS_BITS'(3000);
  localparam logic [TPS_BITS-1:0] TPS_RESET     = TPS_BITS'(12);

  // register indexes
  localparam logic [1:0] REG_PWM_TOP  = 2'd0;
  localparam logic [1:0] REG_REST     = 2'd1;
  localparam logic [1:0] REG_TPS      = 2'd2;

  // request modes
  localparam logic [1:0] MODE_SET     = 2'd0;
  localparam logic [1:0] MODE_SLOW    = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  // result kinds
  localparam logic [2:0] E_ONE        = 3'd0;
  localparam logic [2:0] E_BUSY       = 3'd1;
  localparam logic [2:0] E_INV        = 3'd2;
  localparam logic [2:0] E_PAIR0      = 3'd3;
  localparam logic [2:0] E_PAIR1      = 3'd4;

  localparam logic [CH_BITS-1:0] CH_GROUP = CH_BITS'(0);
  localparam logic [CH_BITS-1:0] CH_A     = CH_BITS'(2);
  localparam logic [CH_BITS-1:0] CH_B     = CH_BITS'(3);

  typedef struct packed {
    logic                load;
    logic                tick;
    logic                clr_busy;
    logic                single_step;
    logic                imm_set;
    logic                gset;
    logic                gstart;
    logic                gfinal;
    logic                step_inc;
    logic                mul_a;
    logic                mul_b;
    logic                div_step;
    logic                store_a;
    logic                gapply;
    logic                push;
    logic [2:0]          ekind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       ch_invalid;
    logic       ch_zero;
    logic       busy;
    logic       grouped;
    logic       tick_hit;
    logic       at_target;
    logic       span_zero;
    logic       g_end;
    logic       div_last;
  } status_t;

  typedef struct packed {
    logic [CH_BITS-1:0]  channel;
    logic [POS_BITS-1:0] position;
    logic [1:0]          status;
    logic                last;
  } res_t;

  // reduce once by the period top
  function automatic logic [POS_BITS-1:0] wrap_pos(input logic [POS_BITS-1:0] v,
                                                   input logic [TOP_BITS-1:0] top);
    logic [TOP_BITS-1:0] ve;
    ve = TOP_BITS'(v);
    return POS_BITS'((ve > top) ? ve - top : ve);
  endfunction

endpackage
`default_nettype wire

// File: sv/spr_obuf.sv
`default_nettype none
module spr_obuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire spr_pkg::res_t push_data,
  output logic               full,
  input  wire logic          out_stall,
  output logic               out_valid,
  output spr_pkg::res_t      out_data
);
  import spr_pkg::*;

  res_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rp_r];

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

// File: sv/spr_dpath.sv
`default_nettype none
module spr_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire spr_pkg::cmd_t                 cmd,
  output spr_pkg::status_t                   sts,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [spr_pkg::CH_BITS-1:0]   in_channel,
  input  wire logic [spr_pkg::POS_BITS-1:0]  in_value,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [spr_pkg::CFG_BITS-1:0]  cfg_wdata,
  output spr_pkg::res_t                      res
);
  import spr_pkg::*;

  logic [TOP_BITS-1:0] pwm_top_r;
  logic [TPS_BITS-1:0] tps_r;

  logic [1:0]          mode_r;
  logic [CH_BITS-1:0]  ch_r;
  logic [POS_BITS-1:0] val_r;

  logic [POS_BITS-1:0] pos_r   [NUM_CHANNELS];
  logic [POS_BITS-1:0] pos_nxt [NUM_CHANNELS];

  logic                busy_r, grouped_r, up_a_r, up_b_r;
  logic [CH_BITS-1:0]  rc_r;
  logic [POS_BITS-1:0] target_r, start_a_r, start_b_r, dist_a_r, dist_b_r, span_r, step_r;
  logic [TPS_BITS-1:0] tc_r;
  logic [POS_BITS-1:0] rem_r, quo_r, off_a_r;
  logic [CNT_BITS-1:0] cnt_r;

  logic [CH_BITS-1:0]  rd_addr;
  logic [POS_BITS-1:0] rd_pos, wv, wt, ga_pos, gb_pos;
  logic [TPS_BITS-1:0] tc_inc;
  logic                g_up_a, g_up_b;
  logic [POS_BITS-1:0] g_dist_a, g_dist_b;
  logic [2*POS_BITS-1:0] prod;
  logic [POS_BITS:0]   div_t;
  logic                div_ge;
  logic                sset_pulse;

  // configuration registers; rest position only matters at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_top_r <= PWM_TOP_RESET;
      tps_r     <= TPS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_PWM_TOP) pwm_top_r <= TOP_BITS'(cfg_wdata);
      if (cfg_index == REG_TPS)     tps_r     <= TPS_BITS'(cfg_wdata);
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      ch_r   <= in_channel;
      val_r  <= in_value;
    end
  end

  // read port: ramp channel on ticks, request channel otherwise
  assign rd_addr = (mode_r == MODE_TICK) ? rc_r : ch_r;
  assign rd_pos  = (32'(rd_addr) < NUM_CHANNELS) ? pos_r[rd_addr] : '0;
  assign wv      = wrap_pos(val_r, pwm_top_r);
  assign wt      = wrap_pos(target_r, pwm_top_r);
  assign tc_inc  = tc_r + TPS_BITS'(1);

  // group setup distances
  assign g_up_a   = pos_r[CH_A] < val_r;
  assign g_up_b   = pos_r[CH_B] < val_r;
  assign g_dist_a = g_up_a ? val_r - pos_r[CH_A] : pos_r[CH_A] - val_r;
  assign g_dist_b = g_up_b ? val_r - pos_r[CH_B] : pos_r[CH_B] - val_r;

  // interpolated group positions
  assign ga_pos = wrap_pos(up_a_r ? start_a_r + off_a_r : start_a_r - off_a_r, pwm_top_r);
  assign gb_pos = wrap_pos(up_b_r ? start_b_r + quo_r : start_b_r - quo_r, pwm_top_r);

  // multiplier and restoring divider step
  assign prod   = (2*POS_BITS)'(step_r) * (2*POS_BITS)'(cmd.mul_b ? dist_b_r : dist_a_r);
  assign div_t  = {rem_r, quo_r[POS_BITS-1]};
  assign div_ge = div_t >= {1'b0, span_r};

  // position updates
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pos_nxt[i] = pos_r[i];
      if (cmd.imm_set) begin
        if (CH_BITS'(i) == ch_r) pos_nxt[i] = wv;
        if (ch_r == CH_GROUP && (CH_BITS'(i) == CH_A || CH_BITS'(i) == CH_B)) pos_nxt[i] = wv;
      end
      if (cmd.single_step && CH_BITS'(i) == rc_r)
        pos_nxt[i] = (rd_pos < target_r) ? rd_pos + POS_BITS'(1) : rd_pos - POS_BITS'(1);
      if (cmd.gstart) begin
        if (CH_BITS'(i) == CH_A) pos_nxt[i] = wrap_pos(start_a_r, pwm_top_r);
        if (CH_BITS'(i) == CH_B) pos_nxt[i] = wrap_pos(start_b_r, pwm_top_r);
      end
      if (cmd.gapply) begin
        if (CH_BITS'(i) == CH_A) pos_nxt[i] = ga_pos;
        if (CH_BITS'(i) == CH_B) pos_nxt[i] = gb_pos;
      end
      if (cmd.gfinal && (CH_BITS'(i) == CH_GROUP || CH_BITS'(i) == CH_A ||
                         CH_BITS'(i) == CH_B))
        pos_nxt[i] = wt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!rst_n) pos_r[i] <= REST_RESET;
      else        pos_r[i] <= pos_nxt[i];
    end
  end

  // single-channel slow set arms on its own pulse
  assign sset_pulse = cmd.clr_busy && mode_r == MODE_SLOW;

  // ramp control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      grouped_r <= 1'b0;
      rc_r      <= '0;
      target_r  <= '0;
      start_a_r <= '0;
      start_b_r <= '0;
      dist_a_r  <= '0;
      dist_b_r  <= '0;
      up_a_r    <= 1'b0;
      up_b_r    <= 1'b0;
      span_r    <= '0;
      step_r    <= '0;
      tc_r      <= '0;
    end else begin
      if (cmd.tick) tc_r <= sts.tick_hit ? '0 : tc_inc;
      if (cmd.single_step) busy_r <= 1'b1;
      if (cmd.clr_busy || cmd.gfinal) busy_r <= 1'b0;
      if (cmd.step_inc) step_r <= step_r + POS_BITS'(1);
      if (cmd.imm_set) begin
      end
      if (mode_r == MODE_SLOW && cmd.gset) begin
        start_a_r <= pos_r[CH_A];
        start_b_r <= pos_r[CH_B];
        up_a_r    <= g_up_a;
        up_b_r    <= g_up_b;
        dist_a_r  <= g_dist_a;
        dist_b_r  <= g_dist_b;
        span_r    <= (g_dist_a > g_dist_b) ? g_dist_b : g_dist_a;
        target_r  <= val_r;
        step_r    <= '0;
        tc_r      <= '0;
      end
      if (sset_pulse) begin
        rc_r      <= ch_r;
        target_r  <= wv;
        grouped_r <= 1'b0;
        tc_r      <= '0;
      end
      if (cmd.gstart) begin
        grouped_r <= 1'b1;
        busy_r    <= 1'b1;
      end
    end
  end

  // shared multiply and serial divide
  always_ff @(posedge clk) begin
    if (cmd.mul_a || cmd.mul_b) begin
      rem_r <= prod[2*POS_BITS-1:POS_BITS];
      quo_r <= prod[POS_BITS-1:0];
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? POS_BITS'(div_t - {1'b0, span_r}) : div_t[POS_BITS-1:0];
      quo_r <= {quo_r[POS_BITS-2:0], div_ge};
      cnt_r <= cnt_r + CNT_BITS'(1);
    end
    if (cmd.store_a) off_a_r <= quo_r;
  end

  // status to the controller
  assign sts.mode       = mode_r;
  assign sts.ch_invalid = !(32'(ch_r) < NUM_CHANNELS);
  assign sts.ch_zero    = (ch_r == CH_GROUP);
  assign sts.busy       = busy_r;
  assign sts.grouped    = grouped_r;
  assign sts.tick_hit   = !(tc_inc < tps_r);
  assign sts.at_target  = (rd_pos == target_r);
  assign sts.span_zero  = (span_r == '0);
  assign sts.g_end      = !(step_r < span_r);
  assign sts.div_last   = (cnt_r == CNT_BITS'(POS_BITS - 1));

  // result item
  always_comb begin
    res.channel  = rd_addr;
    res.position = rd_pos;
    res.status   = ST_OK;
    res.last     = 1'b1;
    case (cmd.ekind)
      E_ONE: begin
      end
      E_BUSY: begin
        res.status = ST_BUSY;
      end
      E_INV: begin
        res.channel  = ch_r;
        res.position = '0;
        res.status   = ST_INVALID;
      end
      E_PAIR0: begin
        res.channel  = CH_A;
        res.position = pos_r[CH_A];
        res.last     = 1'b0;
      end
      E_PAIR1: begin
        res.channel  = CH_B;
        res.position = pos_r[CH_B];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/spr_ctrl.sv
`default_nettype none
module spr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire spr_pkg::status_t sts,
  input  wire logic             obuf_full,
  output spr_pkg::cmd_t         cmd
);
  import spr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SSET2  = 4'd2;
  localparam logic [3:0] S_GSET2  = 4'd3;
  localparam logic [3:0] S_GSTEP  = 4'd4;
  localparam logic [3:0] S_MULA   = 4'd5;
  localparam logic [3:0] S_DIVA   = 4'd6;
  localparam logic [3:0] S_MULB   = 4'd7;
  localparam logic [3:0] S_DIVB   = 4'd8;
  localparam logic [3:0] S_GAPPLY = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [2:0] ekind_r, ekind_nxt;

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ekind_nxt = ekind_r;
    cmd       = '0;
    cmd.ekind = ekind_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (sts.mode == MODE_TICK) begin
          if (sts.busy) begin
            cmd.tick = 1'b1;
            if (sts.tick_hit) begin
              if (sts.grouped) begin
                cmd.step_inc = 1'b1;
                state_nxt    = S_GSTEP;
              end else if (sts.at_target) begin
                cmd.clr_busy = 1'b1;
              end else begin
                cmd.single_step = 1'b1;
                ekind_nxt       = E_ONE;
                state_nxt       = S_EMIT;
              end
            end
          end
        end else if (sts.mode != MODE_NONE) begin
          state_nxt = S_EMIT;
          if (sts.ch_invalid) begin
            ekind_nxt = E_INV;
          end else if (sts.busy) begin
            ekind_nxt = E_BUSY;
          end else if (sts.mode == MODE_SET) begin
            cmd.imm_set = 1'b1;
            ekind_nxt   = sts.ch_zero ? E_PAIR0 : E_ONE;
          end else if (sts.ch_zero) begin
            cmd.gset  = 1'b1;
            state_nxt = S_GSET2;
          end else begin
            // arms the single-channel ramp registers
            cmd.clr_busy = 1'b1;
            state_nxt    = S_SSET2;
          end
        end
      end
      S_SSET2: begin
        cmd.single_step = !sts.at_target;
        ekind_nxt       = E_ONE;
        state_nxt       = S_EMIT;
      end
      S_GSET2: begin
        cmd.gfinal = sts.span_zero;
        cmd.gstart = !sts.span_zero;
        ekind_nxt  = E_PAIR0;
        state_nxt  = S_EMIT;
      end
      S_GSTEP: begin
        if (sts.g_end) begin
          cmd.gfinal = 1'b1;
          ekind_nxt  = E_PAIR0;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_DIVA;
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.store_a = 1'b1;
        cmd.mul_b   = 1'b1;
        state_nxt   = S_DIVB;
      end
      S_DIVB: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_GAPPLY;
      end
      S_GAPPLY: begin
        cmd.gapply = 1'b1;
        ekind_nxt  = E_PAIR0;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.push = !obuf_full;
        if (!obuf_full) begin
          if (ekind_r == E_PAIR0) ekind_nxt = E_PAIR1;
          else                    state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ekind_r <= E_ONE;
    end else begin
      state_r <= state_nxt;
      ekind_r <= ekind_nxt;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !obuf_full) else $error("result pushed into full queue");

  a_div_to_mulb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVA && sts.div_last) |=> state_r == S_MULB)
    else $error("first division did not hand over to second");

  a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && ekind_r == E_PAIR1 && cmd.push) |=> state_r == S_IDLE)
    else $error("second group result did not end the request");

endmodule
`default_nettype wire

// File: sv/servo_position_ramp.sv
`default_nettype none
// Servo pulse-width keeper for seven channels with slew-limited ramps. One request is worked
// at a time: an immediate set, a busy or invalid refusal or a single-channel step is decoded
// and then emits its results; a grouped ramp step also runs the shared 16x16 multiplier and
// the serial divider, which runs one quotient bit per cycle, once for each of the two
// channels. A new request is taken while earlier results still wait in the two-entry output
// queue. Positions reset to 3000; the rest_position register is accepted but has no effect.
module servo_position_ramp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [spr_pkg::CH_BITS-1:0]   in_channel,
  input  wire logic [spr_pkg::POS_BITS-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [spr_pkg::CH_BITS-1:0]        out_channel,
  output logic [spr_pkg::POS_BITS-1:0]       out_position,
  output logic [1:0]                         out_status,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [spr_pkg::CFG_BITS-1:0]  cfg_wdata
);
  import spr_pkg::*;

  cmd_t    cmd;
  status_t sts;
  res_t    res, out_data;
  logic    obuf_full;

  spr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sts       (sts),
    .obuf_full (obuf_full),
    .cmd       (cmd)
  );

  spr_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_mode),
    .in_channel (in_channel),
    .in_value   (in_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .res        (res)
  );

  spr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd.push),
    .push_data (res),
    .full      (obuf_full),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_channel  = out_data.channel;
  assign out_position = out_data.position;
  assign out_status   = out_data.status;
  assign out_last     = out_data.last;

endmodule
`default_nettype wire
